// ===== hdl/apjq_pkg.sv =====
// ----------------------------------------------------------------------------
// apjq_pkg
// Shared types and constants for the aging priority job queue.
// ----------------------------------------------------------------------------
package apjq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 6;
  localparam int JOB_W       = 10;
  localparam int PRI_W       = 4;
  localparam int PG_W        = 8;
  localparam int AGE_W       = 8;
  localparam logic [7:0] MAX_CYCLES_RESET = 8'd10;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_TICK    = 2'd2,
    OP_PROMOTE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SR_RD, S_SR_CK, S_OG_RD, S_OG_WR, S_PUT, S_CG_RD, S_CG_WR,
    S_TK_RD, S_TK_CK, S_FD_RD, S_FD_CK, S_DQ_RD, S_DQ_CK, S_DONE
  } state_t;

  typedef struct packed {
    logic [JOB_W-1:0] job;
    logic [PRI_W-1:0] pri;
    logic [PG_W-1:0]  pages;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [JOB_W-1:0] job_id;
    logic [PRI_W-1:0] pri;
    logic [PG_W-1:0]  pages;
  } req_t;

  typedef struct packed {
    status_t          status;
    entry_t           ent;
    logic [CNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

// ===== hdl/apjq_if.sv =====
// ----------------------------------------------------------------------------
// apjq_if
// Request, result and configuration channels of the job queue.
// ----------------------------------------------------------------------------
interface apjq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [9:0] job_id;
  logic [3:0] priority_req;
  logic [7:0] pages;
  modport source (output valid, operation, job_id, priority_req, pages, input ready);
  modport sink   (input valid, operation, job_id, priority_req, pages, output ready);
endinterface

interface apjq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] out_job_id;
  logic [3:0] out_priority;
  logic [7:0] out_pages;
  logic [7:0] out_age;
  logic [5:0] occupancy;
  modport source (output valid, status, out_job_id, out_priority, out_pages, out_age,
                  occupancy, input ready);
  modport sink   (input valid, status, out_job_id, out_priority, out_pages, out_age,
                  occupancy, output ready);
endinterface

interface apjq_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/apjq_mem.sv =====
// ----------------------------------------------------------------------------
// apjq_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module apjq_mem
  import apjq_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t slots [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      slots[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= slots[req.rd_addr];
    end
  end

endmodule

// ===== hdl/apjq_ctrl.sv =====
// ----------------------------------------------------------------------------
// apjq_ctrl
// Sequencer: search, shift, age and promote over the slot memory.
// ----------------------------------------------------------------------------
module apjq_ctrl
  import apjq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  input  logic [7:0] max_cycles,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res,
  output mem_req_t   mem,
  input  entry_t     rd_data
);

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [JOB_W-1:0] id_r, id_nxt;
  entry_t           hold_r, hold_nxt;
  entry_t           rent_r, rent_nxt;
  status_t          stat_r, stat_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] ti_r, ti_nxt;
  logic [CNT_W-1:0] j_inc, j_dec;
  logic [AGE_W-1:0] age_new;
  logic             fits, promo;

  assign j_inc   = j_r + 1'b1;
  assign j_dec   = j_r - 1'b1;
  assign age_new = (rd_data.age == '1) ? rd_data.age : rd_data.age + 1'b1;
  assign promo   = (age_new != rd_data.age) && (age_new == max_cycles);
  // keep walking while the slot key is ahead of the new job
  assign fits = (op_r == OP_INSERT) ?
                ((rd_data.pri < hold_r.pri) ||
                 ((rd_data.pri == hold_r.pri) && (rd_data.pages <= hold_r.pages))) :
                (rd_data.pri == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          unique case (op_t'(req.op))
            OP_INSERT:  state_nxt = (count_r == CNT_W'(QUEUE_DEPTH)) ? S_DONE : S_SR_RD;
            OP_DEQUEUE: state_nxt = S_DQ_RD;
            OP_TICK:    state_nxt = S_TK_RD;
            OP_PROMOTE: state_nxt = S_FD_RD;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_SR_RD: state_nxt = (j_r == count_r) ? S_OG_RD : S_SR_CK;
      S_SR_CK: state_nxt = fits ? S_SR_RD : S_OG_RD;
      S_OG_RD: state_nxt = (j_r == pos_r) ? S_PUT : S_OG_WR;
      S_OG_WR: state_nxt = S_OG_RD;
      S_PUT:   state_nxt = (op_r == OP_TICK) ? S_TK_RD : S_DONE;
      S_CG_RD: begin
        if (j_inc >= count_r) begin
          state_nxt = (op_r == OP_DEQUEUE) ? S_DONE : S_SR_RD;
        end else begin
          state_nxt = S_CG_WR;
        end
      end
      S_CG_WR: state_nxt = S_CG_RD;
      S_TK_RD: state_nxt = (ti_r == count_r) ? S_DONE : S_TK_CK;
      S_TK_CK: state_nxt = promo ? S_CG_RD : S_TK_RD;
      S_FD_RD: state_nxt = (j_r == count_r) ? S_DONE : S_FD_CK;
      S_FD_CK: state_nxt = (rd_data.job == id_r) ? S_CG_RD : S_FD_RD;
      S_DQ_RD: state_nxt = (count_r == '0) ? S_DONE : S_DQ_CK;
      S_DQ_CK: state_nxt = S_CG_RD;
      S_DONE:  state_nxt = res_ready ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    op_nxt    = op_r;
    id_nxt    = id_r;
    hold_nxt  = hold_r;
    rent_nxt  = rent_r;
    stat_nxt  = stat_r;
    count_nxt = count_r;
    j_nxt     = j_r;
    pos_nxt   = pos_r;
    ti_nxt    = ti_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt   = op_t'(req.op);
          id_nxt   = req.job_id;
          hold_nxt = '{job: req.job_id, pri: req.pri, pages: req.pages, age: '0};
          rent_nxt = '0;
          stat_nxt = ((op_t'(req.op) == OP_INSERT) && (count_r == CNT_W'(QUEUE_DEPTH))) ?
                     ST_FULL : ST_OK;
          j_nxt    = '0;
          ti_nxt   = '0;
        end
      end
      S_SR_RD: begin
        if (j_r == count_r) begin
          pos_nxt = j_r;
          j_nxt   = count_r;
        end
      end
      S_SR_CK: begin
        if (fits) begin
          j_nxt = j_inc;
        end else begin
          pos_nxt = j_r;
          j_nxt   = count_r;
        end
      end
      S_OG_WR: j_nxt = j_dec;
      S_PUT: begin
        count_nxt = count_r + 1'b1;
        ti_nxt    = ti_r + 1'b1;
      end
      S_CG_RD: begin
        if (j_inc >= count_r) begin
          count_nxt = count_r - 1'b1;
          j_nxt     = '0;
        end
      end
      S_CG_WR: j_nxt = j_inc;
      S_TK_CK: begin
        if (promo) begin
          hold_nxt = '{job: rd_data.job, pri: '0, pages: rd_data.pages, age: age_new};
          j_nxt    = ti_r;
        end else begin
          ti_nxt = ti_r + 1'b1;
        end
      end
      S_FD_RD: begin
        if (j_r == count_r) begin
          stat_nxt = ST_NOT_FOUND;
        end
      end
      S_FD_CK: begin
        if (rd_data.job == id_r) begin
          hold_nxt = '{job: rd_data.job, pri: '0, pages: rd_data.pages, age: rd_data.age};
        end else begin
          j_nxt = j_inc;
        end
      end
      S_DQ_RD: begin
        if (count_r == '0) begin
          stat_nxt = ST_EMPTY;
        end
      end
      S_DQ_CK: begin
        rent_nxt = rd_data;
        j_nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    mem       = '0;
    req_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      S_IDLE: req_ready = 1'b1;
      S_SR_RD, S_FD_RD: begin
        mem.rd_en   = (j_r != count_r);
        mem.rd_addr = j_r[IDX_W-1:0];
      end
      S_OG_RD: begin
        mem.rd_en   = (j_r != pos_r);
        mem.rd_addr = j_dec[IDX_W-1:0];
      end
      S_OG_WR, S_CG_WR: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = j_r[IDX_W-1:0];
        mem.wr_data = rd_data;
      end
      S_PUT: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = pos_r[IDX_W-1:0];
        mem.wr_data = hold_r;
      end
      S_CG_RD: begin
        mem.rd_en   = (j_inc < count_r);
        mem.rd_addr = j_inc[IDX_W-1:0];
      end
      S_TK_RD: begin
        mem.rd_en   = (ti_r != count_r);
        mem.rd_addr = ti_r[IDX_W-1:0];
      end
      S_TK_CK: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = ti_r[IDX_W-1:0];
        mem.wr_data = '{job: rd_data.job, pri: rd_data.pri, pages: rd_data.pages,
                        age: age_new};
      end
      S_DQ_RD: begin
        mem.rd_en   = (count_r != '0);
        mem.rd_addr = '0;
      end
      S_DONE: res_valid = 1'b1;
      default: begin
      end
    endcase
  end

  assign res = '{status: stat_r, ent: rent_r, count: count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    op_r   <= op_nxt;
    id_r   <= id_nxt;
    hold_r <= hold_nxt;
    rent_r <= rent_nxt;
    stat_r <= stat_nxt;
    j_r    <= j_nxt;
    pos_r  <= pos_nxt;
    ti_r   <= ti_nxt;
  end

endmodule

// ===== hdl/aging_priority_job_queue.sv =====
// ----------------------------------------------------------------------------
// aging_priority_job_queue
// Sorted job queue with aging, held in one slot memory in sorted order.
// Insert searches for the slot, shifts the tail back and puts the job; dequeue
// reads the head and closes the gap; a full insert or an empty dequeue skips the walk;
// promote and each aged job add a remove, search and reinsert.
// Throughput: one request at a time; the slot-by-slot memory walk sets it,
// and the next request is taken the cycle after the result is handed off.
// A result sits in the output register while the next request is taken.
// Reset: synchronous active-low; queue empties, max_cycles returns to 10.
// ----------------------------------------------------------------------------
module aging_priority_job_queue
  import apjq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  apjq_in_if.sink   in_chan,
  apjq_out_if.source out_chan,
  apjq_cfg_if.sink  cfg_chan
);

  logic [7:0] max_cycles_r;
  req_t       req;
  res_t       res;
  logic       res_valid, res_ready;
  mem_req_t   mem;
  entry_t     rd_data;
  logic       ovalid_r;
  res_t       ores_r;

  // configuration: always ready; the user must write it only while idle, the block does not enforce this
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cycles_r <= MAX_CYCLES_RESET;
    end else if (cfg_chan.valid) begin
      max_cycles_r <= cfg_chan.data;
    end
  end

  assign req = '{op: in_chan.operation, job_id: in_chan.job_id,
                 pri: in_chan.priority_req, pages: in_chan.pages};

  apjq_mem u_mem (
    .clk     (clk),
    .req     (mem),
    .rd_data (rd_data)
  );

  apjq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_chan.valid),
    .req_ready  (in_chan.ready),
    .req        (req),
    .max_cycles (max_cycles_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem        (mem),
    .rd_data    (rd_data)
  );

  // output register: take a result when empty or being drained
  assign res_ready = !ovalid_r || out_chan.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (res_ready) begin
      ovalid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      ores_r <= res;
    end
  end

  assign out_chan.valid        = ovalid_r;
  assign out_chan.status       = ores_r.status;
  assign out_chan.out_job_id   = ores_r.ent.job;
  assign out_chan.out_priority = ores_r.ent.pri;
  assign out_chan.out_pages    = ores_r.ent.pages;
  assign out_chan.out_age      = ores_r.ent.age;
  assign out_chan.occupancy    = OCC_W'(ores_r.count);

  // a taken request blocks the next one until its result is handed off
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request accepted while busy");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_FULL)) |->
      (out_chan.occupancy == OCC_W'(QUEUE_DEPTH)))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_EMPTY)) |-> (out_chan.occupancy == '0))
    else $error("empty status with jobs held");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.occupancy <= OCC_W'(QUEUE_DEPTH)))
    else $error("occupancy beyond depth");

endmodule
